@@ src/bc4_pkg.sv @@
// Shared types and constants for the BC4 block decoder.
`timescale 1ns / 1ps

package bc4_pkg;

    localparam int BLOCK_DIM   = 4;
    localparam int IDX_W       = 3;
    localparam int PIX_W       = 8;
    localparam int PAL_SIZE    = 8;
    localparam int INDEX_W     = BLOCK_DIM * BLOCK_DIM * IDX_W;
    localparam int ROW_IDX_W   = BLOCK_DIM * IDX_W;
    localparam int COUNT_W     = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic [PAL_SIZE-1:0][PIX_W-1:0] palette;
        logic [INDEX_W-1:0]             index_bits;
        logic [COUNT_W-1:0]             cols;
        logic [COUNT_W-1:0]             rows;
    } block_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

@@ src/bc4_front.sv @@
// Front end: accepts compressed blocks and builds the palette.
`timescale 1ns / 1ps

module bc4_front
    import bc4_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                block_valid,
    output logic                block_stall,
    input  logic [PIX_W-1:0]    first_endpoint,
    input  logic [PIX_W-1:0]    second_endpoint,
    input  logic [INDEX_W-1:0]  index_bits,
    input  logic [COUNT_W-1:0]  cols_valid,
    input  logic [COUNT_W-1:0]  rows_valid,
    input  queue_stat_t         q_stat,
    output logic                push,
    output block_entry_t        push_entry
);

    localparam int SUM_W  = 11;
    localparam int PROD_W = 23;
    localparam int LANES  = 6;

    // x/7 for x below 1792 and x/5 for x below 1280 by reciprocal multiply
    function automatic pixel_t div7(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(12'd2341);
        return p[21:14];
    endfunction

    function automatic pixel_t div5(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(12'd3277);
        return p[21:14];
    endfunction

    logic                   stg_vld_reg;
    logic                   stg_vld_next;
    logic                   stg_gt_reg;
    pixel_t                 stg_e0_reg;
    pixel_t                 stg_e1_reg;
    logic [SUM_W-1:0]       stg_sum_reg [LANES];
    logic [SUM_W-1:0]       sum_next [LANES];
    logic [INDEX_W-1:0]     stg_idx_reg;
    logic [COUNT_W-1:0]     stg_cols_reg;
    logic [COUNT_W-1:0]     stg_rows_reg;
    logic [COUNT_W-1:0]     cols_sat;
    logic [COUNT_W-1:0]     rows_sat;
    logic                   gt;
    logic                   take;

    assign block_stall = stg_vld_reg && q_stat.full;
    assign take        = block_valid && !block_stall;
    assign push        = stg_vld_reg && !q_stat.full;
    assign gt          = first_endpoint > second_endpoint;

    assign cols_sat = (cols_valid > COUNT_W'(BLOCK_DIM)) ? COUNT_W'(BLOCK_DIM) : cols_valid;
    assign rows_sat = (rows_valid > COUNT_W'(BLOCK_DIM)) ? COUNT_W'(BLOCK_DIM) : rows_valid;

    // a rows count of zero produces nothing, so the beat is dropped here
    always_comb
    begin
        if (take)
            stg_vld_next = (rows_sat != '0);
        else
            stg_vld_next = stg_vld_reg && q_stat.full;
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (gt)
                sum_next[k] = SUM_W'(6 - k) * SUM_W'(first_endpoint)
                            + SUM_W'(k + 1) * SUM_W'(second_endpoint);
            else if (k < 4)
                sum_next[k] = SUM_W'(4 - k) * SUM_W'(first_endpoint)
                            + SUM_W'(k + 1) * SUM_W'(second_endpoint);
            else
                sum_next[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_vld_reg <= 1'b0;
        else
            stg_vld_reg <= stg_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stg_gt_reg   <= gt;
            stg_e0_reg   <= first_endpoint;
            stg_e1_reg   <= second_endpoint;
            stg_idx_reg  <= index_bits;
            stg_cols_reg <= cols_sat;
            stg_rows_reg <= rows_sat;
            for (int k = 0; k < LANES; k++)
                stg_sum_reg[k] <= sum_next[k];
        end
    end

    always_comb
    begin
        push_entry.palette[0] = stg_e0_reg;
        push_entry.palette[1] = stg_e1_reg;
        for (int k = 0; k < LANES; k++)
        begin
            if (stg_gt_reg)
                push_entry.palette[2 + k] = div7(stg_sum_reg[k]);
            else if (k < 4)
                push_entry.palette[2 + k] = div5(stg_sum_reg[k]);
            else if (k == 4)
                push_entry.palette[2 + k] = '0;
            else
                push_entry.palette[2 + k] = '1;
        end
        push_entry.index_bits = stg_idx_reg;
        push_entry.cols       = stg_cols_reg;
        push_entry.rows       = stg_rows_reg;
    end

endmodule

@@ src/bc4_queue.sv @@
// Short queue of decoded palettes between front end and row sequencer.
`timescale 1ns / 1ps

module bc4_queue
    import bc4_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  block_entry_t push_entry,
    input  logic         pop,
    output block_entry_t head,
    output queue_stat_t  q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    block_entry_t       entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign head         = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ src/bc4_back.sv @@
// Back end: walks the rows of the head block and drives the row channel.
`timescale 1ns / 1ps

module bc4_back
    import bc4_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  block_entry_t         head,
    input  queue_stat_t          q_stat,
    output logic                 pop,
    output logic                 row_valid,
    input  logic                 row_stall,
    output logic [1:0]           row_index,
    output logic [PIX_W-1:0]     pixel_col0,
    output logic [PIX_W-1:0]     pixel_col1,
    output logic [PIX_W-1:0]     pixel_col2,
    output logic [PIX_W-1:0]     pixel_col3,
    output logic [COUNT_W-1:0]   columns_in_row,
    output logic                 last_row
);

    logic                        row_valid_reg;
    logic [1:0]                  row_sel_reg;
    logic [1:0]                  row_index_reg;
    pixel_t [BLOCK_DIM-1:0]      pix_reg;
    pixel_t [BLOCK_DIM-1:0]      pix_next;
    logic [COUNT_W-1:0]          cols_reg;
    logic                        last_reg;
    logic                        load;
    logic                        is_last;
    logic [ROW_IDX_W-1:0]        row_bits;
    logic [IDX_W-1:0]            sel;

    assign load    = !row_valid_reg || !row_stall;
    assign is_last = ({1'b0, row_sel_reg} + COUNT_W'(1)) == head.rows;
    assign pop     = load && !q_stat.empty && is_last;
    assign row_bits = head.index_bits[row_sel_reg * ROW_IDX_W +: ROW_IDX_W];

    always_comb
    begin
        sel = '0;
        for (int c = 0; c < BLOCK_DIM; c++)
        begin
            sel = row_bits[c * IDX_W +: IDX_W];
            if (COUNT_W'(c) < head.cols)
                pix_next[c] = head.palette[sel];
            else
                pix_next[c] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
            row_sel_reg   <= '0;
        end
        else if (load)
        begin
            row_valid_reg <= !q_stat.empty;
            if (!q_stat.empty)
                row_sel_reg <= is_last ? 2'd0 : row_sel_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !q_stat.empty)
        begin
            row_index_reg <= row_sel_reg;
            pix_reg       <= pix_next;
            cols_reg      <= head.cols;
            last_reg      <= is_last;
        end
    end

    assign row_valid      = row_valid_reg;
    assign row_index      = row_index_reg;
    assign pixel_col0     = pix_reg[0];
    assign pixel_col1     = pix_reg[1];
    assign pixel_col2     = pix_reg[2];
    assign pixel_col3     = pix_reg[3];
    assign columns_in_row = cols_reg;
    assign last_row       = last_reg;

endmodule

@@ src/bc4_block_decoder.sv @@
// Top level of the BC4 single-channel block decoder.
//
// Input channel (block_valid / block_stall): one compressed 4x4 block per beat,
// two endpoints, sixteen 3-bit indices, valid column and row counts.
// Output channel (row_valid / row_stall): one beat per pixel row, rows 0 up to
// rows_valid-1, with four pixels (invalid columns read zero), the column count
// and last_row on the final row. A block with a row count of zero yields none.
// Counts above four are treated as four.
// A taken block passes the front-end stage register, the palette queue and the
// back-end output register before row_valid rises for its first row.
// Throughput: one row per cycle while row_stall is low and the palette queue is
// not empty; the row sequencer in the back end sets the pace. The
// front end takes a new block every cycle while the palette queue has room.
// A stall on the row channel holds the current row; the front end keeps
// accepting until its stage and the queue are both full.
// Reset (rst_n low, asynchronous) empties the stage, the queue and the
// output register; no clearing pass is needed.
`timescale 1ns / 1ps

module bc4_block_decoder
    import bc4_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 block_valid,
    output logic                 block_stall,
    input  logic [PIX_W-1:0]     first_endpoint,
    input  logic [PIX_W-1:0]     second_endpoint,
    input  logic [INDEX_W-1:0]   index_bits,
    input  logic [COUNT_W-1:0]   cols_valid,
    input  logic [COUNT_W-1:0]   rows_valid,
    output logic                 row_valid,
    input  logic                 row_stall,
    output logic [1:0]           row_index,
    output logic [PIX_W-1:0]     pixel_col0,
    output logic [PIX_W-1:0]     pixel_col1,
    output logic [PIX_W-1:0]     pixel_col2,
    output logic [PIX_W-1:0]     pixel_col3,
    output logic [COUNT_W-1:0]   columns_in_row,
    output logic                 last_row
);

    logic         push;
    logic         pop;
    block_entry_t push_entry;
    block_entry_t head;
    queue_stat_t  q_stat;

    bc4_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .block_valid     (block_valid),
        .block_stall     (block_stall),
        .first_endpoint  (first_endpoint),
        .second_endpoint (second_endpoint),
        .index_bits      (index_bits),
        .cols_valid      (cols_valid),
        .rows_valid      (rows_valid),
        .q_stat          (q_stat),
        .push            (push),
        .push_entry      (push_entry)
    );

    bc4_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    bc4_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .q_stat         (q_stat),
        .pop            (pop),
        .row_valid      (row_valid),
        .row_stall      (row_stall),
        .row_index      (row_index),
        .pixel_col0     (pixel_col0),
        .pixel_col1     (pixel_col1),
        .pixel_col2     (pixel_col2),
        .pixel_col3     (pixel_col3),
        .columns_in_row (columns_in_row),
        .last_row       (last_row)
    );

`ifndef SYNTH
    a_next_row_follows: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_stall && !last_row |=>
            row_valid && (row_index == $past(row_index) + 2'd1))
        else $error("next row of a block did not follow directly");

    a_cols_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> columns_in_row <= 3'd4)
        else $error("column count above four");

    a_masked_col: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && (columns_in_row < 3'd4) |-> pixel_col3 == 8'd0)
        else $error("pixel beyond valid columns not zero");

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.empty && q_stat.full) && !(pop && q_stat.empty))
        else $error("queue status inconsistent");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the BC4 block decoder: directed and random blocks with idling.
`timescale 1ns / 1ps

module tb_top;
    import bc4_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 8;
    localparam int REPORT_MAX  = 10;
    localparam int RANDOM_FAST = 40;
    localparam int RANDOM_SLOW = 265;

    typedef struct packed {
        logic [1:0]         row_index;
        pixel_t [0:3]       pix;
        logic [COUNT_W-1:0] cols;
        logic               last;
    } pixel_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 block_valid = 1'b0;
    logic                 block_stall;
    logic [PIX_W-1:0]     first_endpoint = '0;
    logic [PIX_W-1:0]     second_endpoint = '0;
    logic [INDEX_W-1:0]   index_bits = '0;
    logic [COUNT_W-1:0]   cols_valid = '0;
    logic [COUNT_W-1:0]   rows_valid = '0;
    logic                 row_valid;
    logic                 row_stall = 1'b0;
    logic [1:0]           row_index;
    logic [PIX_W-1:0]     pixel_col0;
    logic [PIX_W-1:0]     pixel_col1;
    logic [PIX_W-1:0]     pixel_col2;
    logic [PIX_W-1:0]     pixel_col3;
    logic [COUNT_W-1:0]   columns_in_row;
    logic                 last_row;

    pixel_row_t expected_rows[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int gap_max = 0;
    int burst_left = 0;
    int stall_max = 0;
    int stall_left = 0;
    bit stall_on = 1'b0;

    bc4_block_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .block_valid    (block_valid),
        .block_stall    (block_stall),
        .first_endpoint (first_endpoint),
        .second_endpoint(second_endpoint),
        .index_bits     (index_bits),
        .cols_valid     (cols_valid),
        .rows_valid     (rows_valid),
        .row_valid      (row_valid),
        .row_stall      (row_stall),
        .row_index      (row_index),
        .pixel_col0     (pixel_col0),
        .pixel_col1     (pixel_col1),
        .pixel_col2     (pixel_col2),
        .pixel_col3     (pixel_col3),
        .columns_in_row (columns_in_row),
        .last_row       (last_row)
    );

    always #4 clk = ~clk;

    task automatic decode_block_rows(input pixel_t e0, input pixel_t e1,
                                     input logic [INDEX_W-1:0] idx,
                                     input logic [COUNT_W-1:0] cols_in,
                                     input logic [COUNT_W-1:0] rows_in);
        pixel_t           pal [PAL_SIZE];
        int unsigned      cols;
        int unsigned      rows;
        logic [IDX_W-1:0] sel;
        pixel_row_t       row_exp;
        cols = (cols_in > BLOCK_DIM) ? BLOCK_DIM : cols_in;
        rows = (rows_in > BLOCK_DIM) ? BLOCK_DIM : rows_in;
        pal[0] = e0;
        pal[1] = e1;
        if (e0 > e1)
        begin
            for (int k = 0; k < 6; k++)
                pal[2 + k] = pixel_t'(((6 - k) * e0 + (1 + k) * e1) / 7);
        end
        else
        begin
            for (int k = 0; k < 4; k++)
                pal[2 + k] = pixel_t'(((4 - k) * e0 + (1 + k) * e1) / 5);
            pal[6] = 8'd0;
            pal[7] = 8'd255;
        end
        for (int r = 0; r < rows; r++)
        begin
            row_exp.row_index = r[1:0];
            for (int c = 0; c < BLOCK_DIM; c++)
            begin
                sel = idx[IDX_W * (BLOCK_DIM * r + c) +: IDX_W];
                row_exp.pix[c] = (c < cols) ? pal[sel] : 8'd0;
            end
            row_exp.cols = cols[COUNT_W-1:0];
            row_exp.last = (r + 1 == rows);
            expected_rows.push_back(row_exp);
        end
    endtask

    task automatic send_block(input pixel_t e0, input pixel_t e1,
                              input logic [INDEX_W-1:0] idx,
                              input logic [COUNT_W-1:0] cols,
                              input logic [COUNT_W-1:0] rows);
        int gap;
        @(negedge clk);
        block_valid     <= 1'b1;
        first_endpoint  <= e0;
        second_endpoint <= e1;
        index_bits      <= idx;
        cols_valid      <= cols;
        rows_valid      <= rows;
        @(posedge clk);
        while (block_stall)
            @(posedge clk);
        decode_block_rows(e0, e1, idx, cols, rows);
        if (gap_max > 0)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 8);
                gap = $urandom_range(1, gap_max);
                @(negedge clk);
                block_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic send_random_block();
        pixel_t                e0;
        pixel_t                e1;
        logic [INDEX_W-1:0]    idx;
        logic [COUNT_W-1:0]    cols;
        logic [COUNT_W-1:0]    rows;
        int                    pick;
        e0 = pixel_t'($urandom);
        e1 = pixel_t'($urandom);
        pick = $urandom_range(0, 7);
        if (pick == 0)
            e1 = e0;
        else if (pick == 1)
        begin
            e0 = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            e1 = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        idx = INDEX_W'({$urandom, $urandom});
        pick = $urandom_range(0, 9);
        cols = (pick < 6) ? 3'd4 : (pick < 9) ? 3'($urandom_range(1, 3)) : 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 9);
        rows = (pick < 6) ? 3'd4 : (pick < 9) ? 3'($urandom_range(1, 3)) : 3'($urandom_range(0, 7));
        send_block(e0, e1, idx, cols, rows);
    endtask

    // receiver stall pattern: alternating runs of random length
    always @(negedge clk)
    begin
        if (stall_max == 0)
        begin
            stall_on = 1'b0;
            stall_left = 0;
        end
        else if (stall_left == 0)
        begin
            stall_on = ~stall_on;
            stall_left = $urandom_range(1, stall_on ? stall_max : 6);
        end
        if (stall_left > 0)
            stall_left--;
        row_stall <= stall_on;
    end

    always @(posedge clk)
    begin
        pixel_row_t got;
        pixel_row_t want;
        if (rst_n && row_valid && !row_stall)
        begin
            got.row_index = row_index;
            got.pix[0] = pixel_col0;
            got.pix[1] = pixel_col1;
            got.pix[2] = pixel_col2;
            got.pix[3] = pixel_col3;
            got.cols = columns_in_row;
            got.last = last_row;
            if (expected_rows.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected row beat: row %0d pix %h %h %h %h cols %0d last %0b",
                             got.row_index, got.pix[0], got.pix[1], got.pix[2], got.pix[3],
                             got.cols, got.last);
            end
            else
            begin
                want = expected_rows.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"row mismatch: exp row %0d pix %h %h %h %h cols %0d last %0b",
                                  " | got row %0d pix %h %h %h %h cols %0d last %0b"},
                                 want.row_index, want.pix[0], want.pix[1], want.pix[2],
                                 want.pix[3], want.cols, want.last,
                                 got.row_index, got.pix[0], got.pix[1], got.pix[2],
                                 got.pix[3], got.cols, got.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (block_valid && !block_stall) || (row_valid && !row_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic test_palette_extremes();
        logic [INDEX_W-1:0] ramp_up;
        logic [INDEX_W-1:0] ramp_down;
        ramp_up = 48'o7654321076543210;
        ramp_down = 48'o0123456701234567;
        gap_max = 3;
        stall_max = 0;
        send_block(8'd0, 8'd0, ramp_up, 3'd4, 3'd4);
        send_block(8'd255, 8'd255, ramp_down, 3'd4, 3'd4);
        send_block(8'd255, 8'd0, ramp_up, 3'd4, 3'd4);
        send_block(8'd0, 8'd255, ramp_up, 3'd4, 3'd4);
        send_block(8'd1, 8'd0, ramp_down, 3'd4, 3'd4);
        send_block(8'd0, 8'd1, ramp_down, 3'd4, 3'd4);
        send_block(8'd200, 8'd13, {INDEX_W{1'b1}}, 3'd4, 3'd4);
        send_block(8'd13, 8'd200, {INDEX_W{1'b0}}, 3'd4, 3'd4);
    endtask

    task automatic test_edge_blocks();
        logic [INDEX_W-1:0] ramp;
        ramp = 48'o7654321076543210;
        gap_max = 4;
        stall_max = 3;
        send_block(8'd180, 8'd20, ramp, 3'd1, 3'd4);
        send_block(8'd20, 8'd180, ramp, 3'd2, 3'd3);
        send_block(8'd99, 8'd98, ramp, 3'd3, 3'd2);
        send_block(8'd98, 8'd99, ramp, 3'd4, 3'd1);
        send_block(8'd77, 8'd7, ramp, 3'd3, 3'd3);
        send_block(8'd50, 8'd60, ramp, 3'd0, 3'd4);
        send_block(8'd250, 8'd5, ramp, 3'd5, 3'd4);
        send_block(8'd5, 8'd250, ramp, 3'd7, 3'd2);
        send_block(8'd40, 8'd30, ramp, 3'd4, 3'd0);
        send_block(8'd30, 8'd40, ramp, 3'd2, 3'd0);
        send_block(8'd128, 8'd127, ramp, 3'd4, 3'd5);
        send_block(8'd127, 8'd128, ramp, 3'd6, 3'd7);
        send_block(8'd0, 8'd0, ramp, 3'd0, 3'd0);
    endtask

    task automatic test_back_to_back();
        gap_max = 0;
        stall_max = 0;
        repeat (RANDOM_FAST) send_random_block();
    endtask

    task automatic test_random_traffic();
        gap_max = 10;
        stall_max = 4;
        repeat (RANDOM_SLOW / 2) send_random_block();
        gap_max = 3;
        stall_max = 10;
        repeat (RANDOM_SLOW - RANDOM_SLOW / 2) send_random_block();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_palette_extremes();
        test_edge_blocks();
        test_back_to_back();
        test_random_traffic();
        @(negedge clk);
        block_valid <= 1'b0;
        stall_max = 0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && expected_rows.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
